### hw/rtl/bicubic_grid_interpolator_macros.svh
// Assertion macros for the bicubic grid interpolator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BICUBIC_GRID_INTERPOLATOR_MACROS_SVH
`define BICUBIC_GRID_INTERPOLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BGI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BGI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bgi_pkg.sv
// Shared types, constants and weight arithmetic for the bicubic grid interpolator.
// No dependencies; all files but the RAM and the macro header import this package.
package bgi_pkg;

  localparam int COLS_MAX_DEF    = 64;
  localparam int ROWS_MAX_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SIZE_W  = 7;
  localparam int INV_W   = 32;
  localparam int IDX_W   = 8;
  localparam int WGT_W   = 26;
  localparam int QW      = 58;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] REG_COLS     = 8'd0;
  localparam logic [IDX_W-1:0] REG_ROWS     = 8'd1;
  localparam logic [IDX_W-1:0] REG_INV_W    = 8'd2;
  localparam logic [IDX_W-1:0] REG_INV_H    = 8'd3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_DX    = 2'd2,
    KIND_DY    = 2'd3
  } bgi_kind_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_LOC, F_SQ, F_CUBE, F_WGT, F_PUSH
  } bgi_fstate_t;

  typedef enum logic [2:0] {
    B_IDLE, B_FETCH, B_DRAIN, B_DIV, B_SCALE1, B_SCALE2, B_OUT
  } bgi_bstate_t;

  typedef logic [3:0][WGT_W-1:0] bgi_wvec_t;

  typedef struct packed {
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic [INV_W-1:0]  inv_w;
    logic [INV_W-1:0]  inv_h;
  } bgi_cfg_t;

  typedef struct packed {
    logic              is_write;
    bgi_kind_t         kind;
    logic [5:0]        wcol;
    logic [5:0]        wrow;
    logic [31:0]       wdata;
    logic [SIZE_W-1:0] bi;
    logic [SIZE_W-1:0] bj;
    logic [SIZE_W-1:0] nx;
    logic [SIZE_W-1:0] ny;
    bgi_wvec_t         wx;
    bgi_wvec_t         wy;
  } bgi_cmd_t;

  // Six times the cubic Lagrange weights (nodes -1..2) or their slopes, in Q16.
  // Inputs are u, u^2 and u^3 in Q16, Q32 and Q48.
  function automatic bgi_wvec_t calc_weights(input logic signed [18:0] uq,
                                             input logic signed [37:0] u2q,
                                             input logic signed [56:0] u3q,
                                             input logic deriv);
    logic signed [QW-1:0] u1, u2, u3, one;
    logic signed [QW-1:0] q [4];
    logic signed [QW-1:0] rnd;
    bgi_wvec_t w;
    u1  = QW'(uq) <<< 32;
    u2  = QW'(u2q) <<< 16;
    u3  = QW'(u3q);
    one = QW'(1) <<< 48;
    if (deriv) begin
      q[0] = -(3 * u2 - 6 * u1 + 2 * one);
      q[1] = 3 * (3 * u2 - 4 * u1 - one);
      q[2] = -3 * (3 * u2 - 2 * u1 - 2 * one);
      q[3] = 3 * u2 - one;
    end else begin
      q[0] = -(u3 - 3 * u2 + 2 * u1);
      q[1] = 3 * (u3 - 2 * u2 - u1 + 2 * one);
      q[2] = -3 * (u3 - u2 - 2 * u1);
      q[3] = u3 - u1;
    end
    for (int k = 0; k < 4; k++) begin
      rnd  = q[k] + (QW'(1) <<< 31);
      w[k] = rnd[QW-1:32];
    end
    return w;
  endfunction

endpackage

### hw/rtl/bgi_if.sv
// Valid/ready channel interfaces of the bicubic grid interpolator.
// Depends on bgi_pkg for field widths.
interface bgi_in_if;
  import bgi_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [5:0]        write_col;
  logic [5:0]        write_row;
  logic signed [31:0] sample;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  modport source (output valid, kind, write_col, write_row, sample, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, kind, write_col, write_row, sample, pos_x, pos_y,
                  output ready);
endinterface

interface bgi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               saturated;
  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

interface bgi_cfg_if;
  import bgi_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [31:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/bgi_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/bgi_front.sv
// Front end: accepts words, locates the base cell and builds the weight vectors.
// Depends on bgi_pkg and bgi_if; feeds bgi_queue.
module bgi_front #(
  parameter int GRID_COLS_MAX = bgi_pkg::COLS_MAX_DEF,
  parameter int GRID_ROWS_MAX = bgi_pkg::ROWS_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bgi_in_if.sink            in_if,
  input  bgi_pkg::bgi_cfg_t cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output bgi_pkg::bgi_cmd_t push_cmd
);
  import bgi_pkg::*;

  typedef struct packed {
    logic [SIZE_W-1:0] base;
    logic signed [18:0] uq;
  } loc_t;

  bgi_fstate_t st_r, st_nxt;
  logic signed [31:0] posx_r, posy_r;
  logic signed [64:0] sx_r, sy_r;
  logic signed [18:0] ux_r, uy_r;
  logic signed [37:0] ux2_r, uy2_r;
  logic signed [56:0] ux3_r, uy3_r;
  logic [SIZE_W-1:0]  bi_r, bj_r;
  bgi_cmd_t           cmd_r;
  logic               accept, write_ok;
  logic signed [64:0] px, py;
  loc_t               locx, locy;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] c,
                                                 input int max_n);
    if (c < SIZE_W'(2)) return SIZE_W'(2);
    if (int'(c) > max_n) return SIZE_W'(max_n);
    return c;
  endfunction

  // Base cell is floor(s) clamped to [0, n-2]; u is kept within [-2, 2].
  function automatic loc_t locate(input logic signed [64:0] s,
                                  input logic [SIZE_W-1:0] n);
    logic signed [32:0] fi;
    logic [SIZE_W-1:0]  nm2, i;
    logic signed [65:0] u, lim;
    loc_t r;
    fi  = s[64:32];
    nm2 = n - SIZE_W'(2);
    if (fi < 0) begin
      i = '0;
    end else if (fi > $signed({26'd0, nm2})) begin
      i = nm2;
    end else begin
      i = fi[SIZE_W-1:0];
    end
    u   = 66'(s) - $signed({27'd0, i, 32'd0});
    lim = 66'sd1 <<< 33;
    if (u > lim) begin
      u = lim;
    end else if (u < -lim) begin
      u = -lim;
    end
    r.base = i;
    r.uq   = u[34:16];
    return r;
  endfunction

  assign accept   = in_if.valid && in_if.ready;
  assign write_ok = (int'(in_if.write_col) < GRID_COLS_MAX) &&
                    (int'(in_if.write_row) < GRID_ROWS_MAX);
  assign px   = $signed(posx_r) * $signed({1'b0, cfg.inv_w});
  assign py   = $signed(posy_r) * $signed({1'b0, cfg.inv_h});
  assign locx = locate(sx_r, cmd_r.nx);
  assign locy = locate(sy_r, cmd_r.ny);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: begin
        if (accept) begin
          if (bgi_kind_t'(in_if.kind) != KIND_WRITE) begin
            st_nxt = F_MUL;
          end else if (write_ok) begin
            st_nxt = F_PUSH;
          end
        end
      end
      F_MUL:  st_nxt = F_LOC;
      F_LOC:  st_nxt = F_SQ;
      F_SQ:   st_nxt = F_CUBE;
      F_CUBE: st_nxt = F_WGT;
      F_WGT:  st_nxt = F_PUSH;
      F_PUSH: begin
        if (push_ready) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (st_r == F_IDLE);
    push_valid  = (st_r == F_PUSH);
    push_cmd    = cmd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: begin
        posx_r         <= in_if.pos_x;
        posy_r         <= in_if.pos_y;
        cmd_r.is_write <= (bgi_kind_t'(in_if.kind) == KIND_WRITE);
        cmd_r.kind     <= bgi_kind_t'(in_if.kind);
        cmd_r.wcol     <= in_if.write_col;
        cmd_r.wrow     <= in_if.write_row;
        cmd_r.wdata    <= in_if.sample;
        cmd_r.nx       <= eff_size(cfg.cols, GRID_COLS_MAX);
        cmd_r.ny       <= eff_size(cfg.rows, GRID_ROWS_MAX);
      end
      F_MUL: begin
        sx_r <= px - (65'sd1 <<< 31);
        sy_r <= py - (65'sd1 <<< 31);
      end
      F_LOC: begin
        bi_r <= locx.base;
        bj_r <= locy.base;
        ux_r <= locx.uq;
        uy_r <= locy.uq;
      end
      F_SQ: begin
        ux2_r <= ux_r * ux_r;
        uy2_r <= uy_r * uy_r;
      end
      F_CUBE: begin
        ux3_r <= ux2_r * ux_r;
        uy3_r <= uy2_r * uy_r;
      end
      F_WGT: begin
        cmd_r.bi <= bi_r;
        cmd_r.bj <= bj_r;
        cmd_r.wx <= calc_weights(ux_r, ux2_r, ux3_r, cmd_r.kind == KIND_DX);
        cmd_r.wy <= calc_weights(uy_r, uy2_r, uy3_r, cmd_r.kind == KIND_DY);
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/bgi_queue.sv
// Short command queue between the front end and the back end.
// Depends on bgi_pkg for the command type.
module bgi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  bgi_pkg::bgi_cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bgi_pkg::bgi_cmd_t pop_cmd
);
  import bgi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bgi_cmd_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready = (int'(cnt_r) != QUEUE_DEPTH);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= bump(wp_r);
      if (do_pop)  rp_r <= bump(rp_r);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_cmd;
  end
endmodule

### hw/rtl/bgi_back.sv
// Back end: grid memory, stencil fetch and multiply-accumulate, divide by 36,
// derivative scaling and the result register. Depends on bgi_pkg, bgi_if, bgi_ram.
module bgi_back #(
  parameter int GRID_COLS_MAX = bgi_pkg::COLS_MAX_DEF,
  parameter int GRID_ROWS_MAX = bgi_pkg::ROWS_MAX_DEF,
  parameter int SAMPLE_BITS   = bgi_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bgi_pkg::bgi_cfg_t cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  bgi_pkg::bgi_cmd_t pop_cmd,
  output logic              busy,
  bgi_out_if.source         out_if
);
  import bgi_pkg::*;

  localparam int STORE_BITS = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int DEPTH      = GRID_COLS_MAX * GRID_ROWS_MAX;
  localparam int AW         = $clog2(DEPTH);
  localparam int TW         = 72;

  bgi_bstate_t st_r, st_nxt;
  bgi_cmd_t    cmd_r;
  logic [3:0]  cnt_r;
  logic [2:0]  dcnt_r;

  logic               ram_we;
  logic [AW-1:0]      ram_addr, waddr, faddr;
  logic [STORE_BITS-1:0] ram_rdata;
  logic [SIZE_W-1:0]  fcol, frow;

  logic               rd_v_r, p1_v_r, rs_v_r, p2_v_r, tot_done_r;
  logic [3:0]         rd_tag_r, p1_tag_r;
  logic [1:0]         rs_a_r, p2_a_r;
  logic signed [57:0] prod1_r;
  logic signed [59:0] rowacc_r, accn, accr;
  logic signed [43:0] rs_r;
  logic signed [69:0] prod2_r;
  logic signed [TW-1:0] total_r, vsum;
  logic signed [31:0] fval;

  logic [63:0]        div_r, div_nxt, biased;
  logic [3:0]         rem_r, rem_nxt;
  logic signed [55:0] qv;
  logic [54:0]        mag;
  logic [31:0]        inv_sel;
  logic [63:0]        ph_r;
  logic [47:0]        pl_r;
  logic               big_r, neg_r;
  logic [64:0]        p_r;

  logic               out_valid_r, out_sat_r, res_sat;
  logic signed [31:0] out_res_r, res_val;
  logic               load_out;

  // Index -1 reflects to 1 and index n clamps to n-1; k holds index plus one.
  function automatic logic [SIZE_W-1:0] sidx(input logic [SIZE_W-1:0] base,
                                             input logic [1:0] off,
                                             input logic [SIZE_W-1:0] n);
    logic [SIZE_W:0] k;
    k = {1'b0, base} + {{(SIZE_W-1){1'b0}}, off};
    if (k == '0) return SIZE_W'(1);
    if (k > {1'b0, n}) return n - SIZE_W'(1);
    return SIZE_W'(k - 1'b1);
  endfunction

  bgi_ram #(.WIDTH(STORE_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (STORE_BITS'(pop_cmd.wdata)),
    .rdata (ram_rdata)
  );

  assign waddr = AW'(int'(pop_cmd.wrow) * GRID_COLS_MAX + int'(pop_cmd.wcol));
  assign fcol  = sidx(cmd_r.bi, cnt_r[3:2], cmd_r.nx);
  assign frow  = sidx(cmd_r.bj, cnt_r[1:0], cmd_r.ny);
  assign faddr = AW'(int'(frow) * GRID_COLS_MAX + int'(fcol));
  assign fval  = 32'($signed(ram_rdata));

  assign accn  = (p1_tag_r[1:0] == 2'd0) ? 60'(prod1_r) : rowacc_r + 60'(prod1_r);
  assign accr  = accn + 60'sd32768;

  // Divide by 36*2^16 with round half up: shift by 2^18, then divide by 9
  // on a biased, nonnegative copy so that the long division floors.
  assign vsum   = total_r + TW'(1179648);
  assign biased = 64'($signed(vsum[TW-1:18])) + (64'd9 << 54);
  assign qv     = $signed(div_r[55:0] - (56'd1 << 54));
  assign mag    = qv[55] ? 55'(-qv) : 55'(qv);
  assign inv_sel = (cmd_r.kind == KIND_DX) ? cfg.inv_w : cfg.inv_h;

  always_comb begin
    logic [3:0] rem;
    logic [4:0] t;
    logic [7:0] qb;
    rem = rem_r;
    qb  = '0;
    for (int j = 0; j < 8; j++) begin
      t = {rem, div_r[63-j]};
      if (t >= 5'd9) begin
        qb[7-j] = 1'b1;
        rem     = 4'(t - 5'd9);
      end else begin
        rem     = t[3:0];
      end
    end
    div_nxt = {div_r[55:0], qb};
    rem_nxt = rem;
  end

  always_comb begin
    res_sat = 1'b0;
    res_val = qv[31:0];
    if (cmd_r.kind == KIND_VALUE) begin
      if (qv > 56'sd2147483647) begin
        res_sat = 1'b1;
        res_val = 32'sh7FFFFFFF;
      end else if (qv < -56'sd2147483648) begin
        res_sat = 1'b1;
        res_val = 32'sh80000000;
      end
    end else if (neg_r) begin
      if (big_r || p_r > 65'd2147483648) begin
        res_sat = 1'b1;
        res_val = 32'sh80000000;
      end else begin
        res_val = -$signed(p_r[31:0]);
      end
    end else begin
      if (big_r || p_r > 65'd2147483647) begin
        res_sat = 1'b1;
        res_val = 32'sh7FFFFFFF;
      end else begin
        res_val = $signed(p_r[31:0]);
      end
    end
  end

  assign load_out = (st_r == B_OUT) && (!out_valid_r || out_if.ready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (pop_valid && !pop_cmd.is_write) st_nxt = B_FETCH;
      end
      B_FETCH: begin
        if (cnt_r == 4'd15) st_nxt = B_DRAIN;
      end
      B_DRAIN: begin
        if (tot_done_r) st_nxt = B_DIV;
      end
      B_DIV: begin
        if (dcnt_r == 3'd7) begin
          st_nxt = (cmd_r.kind == KIND_VALUE) ? B_OUT : B_SCALE1;
        end
      end
      B_SCALE1: st_nxt = B_SCALE2;
      B_SCALE2: st_nxt = B_OUT;
      B_OUT: begin
        if (load_out) st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (st_r == B_IDLE);
    busy      = (st_r != B_IDLE);
    ram_we    = (st_r == B_IDLE) && pop_valid && pop_cmd.is_write;
    ram_addr  = ram_we ? waddr : faddr;
    out_if.valid     = out_valid_r;
    out_if.result    = out_res_r;
    out_if.saturated = out_sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      rd_v_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      rs_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      tot_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rd_v_r <= (st_r == B_FETCH);
      p1_v_r <= rd_v_r;
      rs_v_r <= p1_v_r && (p1_tag_r[1:0] == 2'd3);
      p2_v_r <= rs_v_r;
      if (st_r == B_DRAIN && tot_done_r) begin
        tot_done_r <= 1'b0;
      end else if (p2_v_r && p2_a_r == 2'd3) begin
        tot_done_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && pop_valid) cmd_r <= pop_cmd;
    cnt_r <= (st_r == B_FETCH) ? cnt_r + 4'd1 : 4'd0;

    rd_tag_r <= cnt_r;
    prod1_r  <= fval * $signed(cmd_r.wy[rd_tag_r[1:0]]);
    p1_tag_r <= rd_tag_r;
    if (p1_v_r) begin
      rowacc_r <= accn;
      rs_r     <= accr[59:16];
      rs_a_r   <= p1_tag_r[3:2];
    end
    prod2_r <= rs_r * $signed(cmd_r.wx[rs_a_r]);
    p2_a_r  <= rs_a_r;
    if (p2_v_r) begin
      total_r <= (p2_a_r == 2'd0) ? TW'(prod2_r) : total_r + TW'(prod2_r);
    end

    if (st_r == B_DRAIN) begin
      div_r  <= biased;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (st_r == B_DIV) begin
      div_r  <= div_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + 3'd1;
    end

    if (st_r == B_SCALE1) begin
      ph_r  <= 64'(mag[47:16]) * 64'(inv_sel);
      pl_r  <= 48'(mag[15:0]) * 48'(inv_sel);
      big_r <= (mag[54:48] != '0) && (inv_sel != '0);
      neg_r <= qv[55];
    end
    if (st_r == B_SCALE2) begin
      p_r <= 65'(ph_r) + 65'((49'(pl_r) + 49'd32768) >> 16);
    end

    if (load_out) begin
      out_res_r <= res_val;
      out_sat_r <= res_sat;
    end
  end
endmodule

### hw/rtl/bicubic_grid_interpolator.sv
// Bicubic grid interpolator. A write word stores one Q16.16 sample; a query word
// returns the interpolated value, d/dx or d/dy as one saturated result word. The
// front end takes a word every cycle it is free: an in-range write goes straight to
// its push, a query first passes position multiply, cell search and two weight
// multiplies. A short queue feeds the back end, which reads the sixteen stencil
// samples from one single-port grid memory, one per cycle, drains a four-stage
// multiply-add, divides by 36 by long division and scales derivatives. The back
// end takes a new query only once it is through with the last one, which sets the
// sustained query rate; the front end overlaps it. A write is stored while idle.
// The grid memory has no reset; a stencil that touches an unwritten entry is
// undefined. Configuration has its own always-ready write channel.
`include "bicubic_grid_interpolator_macros.svh"

module bicubic_grid_interpolator #(
  parameter int GRID_COLS_MAX = bgi_pkg::COLS_MAX_DEF,
  parameter int GRID_ROWS_MAX = bgi_pkg::ROWS_MAX_DEF,
  parameter int SAMPLE_BITS   = bgi_pkg::SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  bgi_in_if.sink     in_if,
  bgi_out_if.source  out_if,
  bgi_cfg_if.sink    cfg_if
);
  import bgi_pkg::*;

  bgi_cfg_t cfg_r;
  bgi_cmd_t push_cmd, pop_cmd;
  logic     push_valid, push_ready, pop_valid, pop_ready, bk_busy;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols  <= SIZE_W'(64);
      cfg_r.rows  <= SIZE_W'(64);
      cfg_r.inv_w <= INV_W'(65536);
      cfg_r.inv_h <= INV_W'(65536);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_COLS:  cfg_r.cols  <= cfg_if.data[SIZE_W-1:0];
        REG_ROWS:  cfg_r.rows  <= cfg_if.data[SIZE_W-1:0];
        REG_INV_W: cfg_r.inv_w <= cfg_if.data;
        REG_INV_H: cfg_r.inv_h <= cfg_if.data;
        default: ;
      endcase
    end
  end

  bgi_front #(.GRID_COLS_MAX(GRID_COLS_MAX), .GRID_ROWS_MAX(GRID_ROWS_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  bgi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  bgi_back #(
    .GRID_COLS_MAX (GRID_COLS_MAX),
    .GRID_ROWS_MAX (GRID_ROWS_MAX),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .busy      (bk_busy),
    .out_if    (out_if)
  );

  // Checks that the front end is not ready in the cycle after taking a word (an out-of-range write breaks this).
  `BGI_ASSERT_NEXT(a_front_busy, in_if.valid && in_if.ready, !in_if.ready, "front took back-to-back words")
  // A query taken from the queue must start the back end.
  `BGI_ASSERT_NEXT(a_back_start, pop_valid && pop_ready && !pop_cmd.is_write, bk_busy, "query did not start back end")
endmodule
